>>> src/eoa_pkg.sv
// Shared types, constants and helpers for the encoder odometry accumulator.
package eoa_pkg;

  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned SCALE_W     = 24;
  localparam int unsigned INC_W       = 32;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned OUT_ACC_W   = 48;
  localparam int unsigned MUL_A_W     = 33;
  localparam int unsigned PROD_W      = MUL_A_W + SCALE_W + 1;
  localparam int unsigned WIDE_W      = 64;
  localparam int unsigned IN_DATA_W   = 8;
  localparam int unsigned IN_USER_W   = 2;
  localparam int unsigned OUT_DATA_W  = 2 * INC_W + 4 * OUT_ACC_W + 2 * TOTAL_W;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  localparam logic [SCALE_W-1:0] MM_PER_COUNT_RESET = 24'd18000;
  localparam logic [SCALE_W-1:0] DEG_PER_MM_RESET   = 24'd46000;

  localparam logic [2:0] REG_LEFT_REV  = 3'd0;
  localparam logic [2:0] REG_RIGHT_REV = 3'd1;
  localparam logic [2:0] REG_MM_LEFT   = 3'd2;
  localparam logic [2:0] REG_MM_RIGHT  = 3'd3;
  localparam logic [2:0] REG_DEG       = 3'd4;

  localparam logic [IN_USER_W-1:0] ACT_LEFT  = 2'd0;
  localparam logic [IN_USER_W-1:0] ACT_RIGHT = 2'd1;
  localparam logic [IN_USER_W-1:0] ACT_TICK  = 2'd2;
  localparam logic [IN_USER_W-1:0] ACT_CLEAR = 2'd3;

  typedef enum logic [1:0] {
    CMD_STEP_L,
    CMD_STEP_R,
    CMD_TICK,
    CMD_CLEAR
  } cmd_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_L,
    BK_MUL_R,
    BK_SAT_R,
    BK_MUL_T,
    BK_WRITE
  } bk_state_e;

  typedef struct packed {
    cmd_e op;
    logic up;
  } cmd_t;

  typedef struct packed {
    logic               left_rev;
    logic               right_rev;
    logic [SCALE_W-1:0] mm_left;
    logic [SCALE_W-1:0] mm_right;
    logic [SCALE_W-1:0] deg;
  } cfg_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]   total_right;
    logic [TOTAL_W-1:0]   total_left;
    logic [OUT_ACC_W-1:0] wheel_right;
    logic [OUT_ACC_W-1:0] wheel_left;
    logic [OUT_ACC_W-1:0] angle;
    logic [OUT_ACC_W-1:0] distance;
    logic [INC_W-1:0]     increment_right;
    logic [INC_W-1:0]     increment_left;
  } result_t;

  function automatic logic signed [INC_W-1:0] sat_inc(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-INC_W:0] upper;
    logic signed [INC_W-1:0] r;
    upper = p[PROD_W-1:INC_W-1];
    if ((&upper) || !(|upper)) begin
      r = p[INC_W-1:0];
    end else if (p[PROD_W-1]) begin
      r = {1'b1, {(INC_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(INC_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> src/eoa_cfg_regs.sv
// Configuration register file behind the APB-style port.
module eoa_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [eoa_pkg::ADDR_W-1:0] paddr,
  input  logic [eoa_pkg::DATA_W-1:0] pwdata,
  output logic [eoa_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output eoa_pkg::cfg_t              cfg_o
);

  eoa_pkg::cfg_t cfg_q;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_rev  <= 1'b0;
      cfg_q.right_rev <= 1'b0;
      cfg_q.mm_left   <= eoa_pkg::MM_PER_COUNT_RESET;
      cfg_q.mm_right  <= eoa_pkg::MM_PER_COUNT_RESET;
      cfg_q.deg       <= eoa_pkg::DEG_PER_MM_RESET;
    end else if (wr_en) begin
      case (idx)
        eoa_pkg::REG_LEFT_REV:  cfg_q.left_rev  <= pwdata[0];
        eoa_pkg::REG_RIGHT_REV: cfg_q.right_rev <= pwdata[0];
        eoa_pkg::REG_MM_LEFT:   cfg_q.mm_left   <= pwdata[eoa_pkg::SCALE_W-1:0];
        eoa_pkg::REG_MM_RIGHT:  cfg_q.mm_right  <= pwdata[eoa_pkg::SCALE_W-1:0];
        eoa_pkg::REG_DEG:       cfg_q.deg       <= pwdata[eoa_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      eoa_pkg::REG_LEFT_REV:  prdata = {{(eoa_pkg::DATA_W-1){1'b0}}, cfg_q.left_rev};
      eoa_pkg::REG_RIGHT_REV: prdata = {{(eoa_pkg::DATA_W-1){1'b0}}, cfg_q.right_rev};
      eoa_pkg::REG_MM_LEFT:   prdata = eoa_pkg::DATA_W'(cfg_q.mm_left);
      eoa_pkg::REG_MM_RIGHT:  prdata = eoa_pkg::DATA_W'(cfg_q.mm_right);
      eoa_pkg::REG_DEG:       prdata = eoa_pkg::DATA_W'(cfg_q.deg);
      default:                prdata = '0;
    endcase
  end

endmodule

>>> src/eoa_front.sv
// Input side: accepts beats, decodes them into commands and queues them.
module eoa_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [eoa_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic [eoa_pkg::IN_USER_W-1:0] s_axis_tuser,
  input  eoa_pkg::cfg_t                 cfg_i,
  output logic                          cmd_valid_o,
  output eoa_pkg::cmd_t                 cmd_o,
  input  logic                          cmd_pop_i
);

  eoa_pkg::cmd_t                 mem_q [eoa_pkg::QUEUE_DEPTH];
  logic [eoa_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [eoa_pkg::QCNT_W-1:0]    count_q;
  eoa_pkg::cmd_t                 entry;
  logic                          push, pop;

  assign s_axis_tready = count_q != eoa_pkg::QCNT_W'(eoa_pkg::QUEUE_DEPTH);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = count_q != '0;
  assign pop           = cmd_pop_i && cmd_valid_o;
  assign cmd_o         = mem_q[rd_ptr_q];

  always_comb begin
    case (s_axis_tuser)
      eoa_pkg::ACT_LEFT: begin
        entry.op = eoa_pkg::CMD_STEP_L;
        entry.up = s_axis_tdata[0] ^ cfg_i.left_rev;
      end
      eoa_pkg::ACT_RIGHT: begin
        entry.op = eoa_pkg::CMD_STEP_R;
        entry.up = s_axis_tdata[0] ^ cfg_i.right_rev;
      end
      eoa_pkg::ACT_TICK: begin
        entry.op = eoa_pkg::CMD_TICK;
        entry.up = 1'b0;
      end
      default: begin
        entry.op = eoa_pkg::CMD_CLEAR;
        entry.up = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> src/eoa_back.sv
// Execution side: period counters, shared multiplier, accumulators, result register.
module eoa_back #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned ACCUM_WIDTH = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  eoa_pkg::cfg_t                  cfg_i,
  input  logic                           cmd_valid_i,
  input  eoa_pkg::cmd_t                  cmd_i,
  output logic                           cmd_pop_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [eoa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  eoa_pkg::bk_state_e state_q, state_d;

  logic signed [COUNT_WIDTH-1:0]         period_l_q, period_r_q, dl_q, dr_q;
  logic [eoa_pkg::TOTAL_W-1:0]           total_l_q, total_r_q;
  logic signed [ACCUM_WIDTH-1:0]         dist_l_q, dist_r_q, trav_q, head_q;
  logic signed [ACCUM_WIDTH-1:0]         dist_l_d, dist_r_d, trav_d, head_d;
  logic signed [eoa_pkg::PROD_W-1:0]     prod_q, prod_d;
  logic signed [eoa_pkg::INC_W-1:0]      il_q, ir_q;
  logic signed [eoa_pkg::MUL_A_W-1:0]    mul_a, fwd_sum, fwd;
  logic [eoa_pkg::SCALE_W-1:0]           mul_b;
  logic signed [eoa_pkg::WIDE_W-1:0]     turn;
  logic                                  m_valid_q, out_free, write_en;
  eoa_pkg::result_t                      res_q, res_d;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = res_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      eoa_pkg::BK_IDLE: begin
        if (cmd_valid_i && cmd_i.op == eoa_pkg::CMD_TICK) begin
          state_d = eoa_pkg::BK_MUL_L;
        end
      end
      eoa_pkg::BK_MUL_L: state_d = eoa_pkg::BK_MUL_R;
      eoa_pkg::BK_MUL_R: state_d = eoa_pkg::BK_SAT_R;
      eoa_pkg::BK_SAT_R: state_d = eoa_pkg::BK_MUL_T;
      eoa_pkg::BK_MUL_T: state_d = eoa_pkg::BK_WRITE;
      eoa_pkg::BK_WRITE: begin
        if (out_free) begin
          state_d = eoa_pkg::BK_IDLE;
        end
      end
      default: state_d = eoa_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    write_en  = 1'b0;
    mul_a     = eoa_pkg::MUL_A_W'(ir_q) - eoa_pkg::MUL_A_W'(il_q);
    mul_b     = cfg_i.deg;
    case (state_q)
      eoa_pkg::BK_IDLE: cmd_pop_o = cmd_valid_i;
      eoa_pkg::BK_MUL_L: begin
        mul_a = eoa_pkg::MUL_A_W'(dl_q);
        mul_b = cfg_i.mm_left;
      end
      eoa_pkg::BK_MUL_R: begin
        mul_a = eoa_pkg::MUL_A_W'(dr_q);
        mul_b = cfg_i.mm_right;
      end
      eoa_pkg::BK_WRITE: write_en = out_free;
      default: ;
    endcase
  end

  assign prod_d  = mul_a * $signed({1'b0, mul_b});
  assign fwd_sum = eoa_pkg::MUL_A_W'(il_q) + eoa_pkg::MUL_A_W'(ir_q);
  assign fwd     = fwd_sum >>> 1;
  assign turn    = eoa_pkg::WIDE_W'(prod_q) >>> FRAC_BITS;

  assign dist_l_d = dist_l_q + ACCUM_WIDTH'(il_q);
  assign dist_r_d = dist_r_q + ACCUM_WIDTH'(ir_q);
  assign trav_d   = trav_q + ACCUM_WIDTH'(fwd);
  assign head_d   = head_q + ACCUM_WIDTH'(turn);

  always_comb begin
    res_d.increment_left  = il_q;
    res_d.increment_right = ir_q;
    res_d.distance        = eoa_pkg::OUT_ACC_W'(trav_d);
    res_d.angle           = eoa_pkg::OUT_ACC_W'(head_d);
    res_d.wheel_left      = eoa_pkg::OUT_ACC_W'(dist_l_d);
    res_d.wheel_right     = eoa_pkg::OUT_ACC_W'(dist_r_d);
    res_d.total_left      = total_l_q;
    res_d.total_right     = total_r_q;
  end

  always_ff @(posedge clk_i) begin
    if (write_en) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      eoa_pkg::BK_MUL_L: prod_q <= prod_d;
      eoa_pkg::BK_MUL_R: begin
        prod_q <= prod_d;
        il_q   <= eoa_pkg::sat_inc(prod_q);
      end
      eoa_pkg::BK_SAT_R: ir_q   <= eoa_pkg::sat_inc(prod_q);
      eoa_pkg::BK_MUL_T: prod_q <= prod_d;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= eoa_pkg::BK_IDLE;
      m_valid_q  <= 1'b0;
      period_l_q <= '0;
      period_r_q <= '0;
      dl_q       <= '0;
      dr_q       <= '0;
      total_l_q  <= '0;
      total_r_q  <= '0;
      dist_l_q   <= '0;
      dist_r_q   <= '0;
      trav_q     <= '0;
      head_q     <= '0;
    end else begin
      state_q <= state_d;
      if (write_en) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (write_en) begin
        dist_l_q <= dist_l_d;
        dist_r_q <= dist_r_d;
        trav_q   <= trav_d;
        head_q   <= head_d;
      end
      if (cmd_pop_o) begin
        case (cmd_i.op)
          eoa_pkg::CMD_STEP_L: begin
            if (cmd_i.up && period_l_q != CNT_MAX) begin
              period_l_q <= period_l_q + 1'b1;
            end else if (!cmd_i.up && period_l_q != CNT_MIN) begin
              period_l_q <= period_l_q - 1'b1;
            end
          end
          eoa_pkg::CMD_STEP_R: begin
            if (cmd_i.up && period_r_q != CNT_MAX) begin
              period_r_q <= period_r_q + 1'b1;
            end else if (!cmd_i.up && period_r_q != CNT_MIN) begin
              period_r_q <= period_r_q - 1'b1;
            end
          end
          eoa_pkg::CMD_TICK: begin
            dl_q       <= period_l_q;
            dr_q       <= period_r_q;
            period_l_q <= '0;
            period_r_q <= '0;
            total_l_q  <= total_l_q + eoa_pkg::TOTAL_W'(eoa_pkg::MUL_A_W'(period_l_q));
            total_r_q  <= total_r_q + eoa_pkg::TOTAL_W'(eoa_pkg::MUL_A_W'(period_r_q));
          end
          default: begin
            period_l_q <= '0;
            period_r_q <= '0;
            total_l_q  <= '0;
            total_r_q  <= '0;
            dist_l_q   <= '0;
            dist_r_q   <= '0;
            trav_q     <= '0;
            head_q     <= '0;
          end
        endcase
      end
    end
  end

endmodule

>>> src/encoder_odometry_accumulator.sv
// Top level of the differential-drive encoder odometry accumulator.
//
//   channel  direction  handshake                 payload
//   s_axis   in         tvalid/tready             tdata b_level, tuser action
//   m_axis   out        tvalid/tready             tdata eight result fields
//   apb      in/out     psel/penable/pready       5 registers at 4*i
//
// Edge and clear beats are handled in the execution unit's idle state; an update
// tick steps through MUL_L, MUL_R, SAT_R, MUL_T and WRITE, with three passes
// through the one shared 33x25 multiplier plus saturation and accumulation
// steps. A four-entry command queue lets input beats keep arriving while a tick
// is worked off or its result waits on m_axis_tready. Reset clears all counters,
// totals and accumulators and loads the register defaults; no sweep follows reset.
module encoder_odometry_accumulator #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned ACCUM_WIDTH = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] b_level, [7:1] zero
  input  logic [eoa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] action
  input  logic [eoa_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] increment_left, [63:32] increment_right, [111:64] distance_out,
  // [159:112] angle_out, [207:160] left wheel distance, [255:208] right wheel distance,
  // [287:256] total_left_out, [319:288] total_right_out
  output logic [eoa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [eoa_pkg::ADDR_W-1:0]     paddr,
  input  logic [eoa_pkg::DATA_W-1:0]     pwdata,
  output logic [eoa_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  eoa_pkg::cfg_t cfg;
  eoa_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_pop;

  eoa_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  eoa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_i         (cfg),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  eoa_back #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .ACCUM_WIDTH (ACCUM_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> tb/tb_encoder_odometry_accumulator.sv
// Self-checking testbench for the encoder odometry accumulator: directed and random beats.
`timescale 1ns / 1ps

module tb_encoder_odometry_accumulator;

  localparam int          HOLD_CYCLES  = 300;
  localparam int          SETTLE       = 40;
  localparam int          CYCLE_LIMIT  = 2000000;
  localparam int          MIX_ITEMS    = 350;
  localparam int          SAT_EDGES    = 130;
  localparam int          FRAC         = 16;
  localparam logic [23:0] SCALE_MAX    = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0]       act;
    logic             b;
    logic             pin;
    eoa_pkg::result_t val;
  } row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [eoa_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [eoa_pkg::IN_USER_W-1:0]  s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [eoa_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [eoa_pkg::ADDR_W-1:0]     paddr;
  logic [eoa_pkg::DATA_W-1:0]     pwdata;
  logic [eoa_pkg::DATA_W-1:0]     prdata;
  logic                           pready;

  // odometry state and register copy
  logic signed [15:0] per_l, per_r;
  logic [31:0]        tot_l, tot_r;
  logic [47:0]        whl_l, whl_r, trav, head;
  logic               rev_l, rev_r;
  logic [23:0]        mm_l, mm_r, deg;

  eoa_pkg::result_t odo_expect_q[$];
  row_t             pin_q[$];
  row_t             dir_rows[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_req;
  int  mismatches;
  int  beats_in;
  int  results_seen;
  int  cycles;

  encoder_odometry_accumulator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic eoa_pkg::result_t pinned(input longint il, input longint ir,
                                              input longint fwd_acc, input longint ang,
                                              input longint dl, input longint dr,
                                              input longint tl, input longint tr);
    eoa_pkg::result_t r;
    r.increment_left  = il[31:0];
    r.increment_right = ir[31:0];
    r.distance        = fwd_acc[47:0];
    r.angle           = ang[47:0];
    r.wheel_left      = dl[47:0];
    r.wheel_right     = dr[47:0];
    r.total_left      = tl[31:0];
    r.total_right     = tr[31:0];
    return r;
  endfunction

  function automatic bit odo_advance(input logic [1:0] act, input logic b,
                                     output eoa_pkg::result_t res);
    longint dl, dr, il, ir, fwd, turn;
    res = '0;
    case (act)
      eoa_pkg::ACT_LEFT: begin
        if (b ^ rev_l) begin
          if (per_l != 16'sh7FFF) per_l = per_l + 16'sd1;
        end else if (per_l != 16'sh8000) begin
          per_l = per_l - 16'sd1;
        end
        return 1'b0;
      end
      eoa_pkg::ACT_RIGHT: begin
        if (b ^ rev_r) begin
          if (per_r != 16'sh7FFF) per_r = per_r + 16'sd1;
        end else if (per_r != 16'sh8000) begin
          per_r = per_r - 16'sd1;
        end
        return 1'b0;
      end
      eoa_pkg::ACT_CLEAR: begin
        per_l = '0;
        per_r = '0;
        tot_l = '0;
        tot_r = '0;
        whl_l = '0;
        whl_r = '0;
        trav  = '0;
        head  = '0;
        return 1'b0;
      end
      default: begin
        dl    = per_l;
        dr    = per_r;
        per_l = '0;
        per_r = '0;
        tot_l = tot_l + dl[31:0];
        tot_r = tot_r + dr[31:0];
        il    = clip32(dl * longint'({40'd0, mm_l}));
        ir    = clip32(dr * longint'({40'd0, mm_r}));
        whl_l = whl_l + il[47:0];
        whl_r = whl_r + ir[47:0];
        fwd   = (il + ir) >>> 1;
        turn  = ((ir - il) * longint'({40'd0, deg})) >>> FRAC;
        trav  = trav + fwd[47:0];
        head  = head + turn[47:0];
        res.increment_left  = il[31:0];
        res.increment_right = ir[31:0];
        res.distance        = trav;
        res.angle           = head;
        res.wheel_left      = whl_l;
        res.wheel_right     = whl_r;
        res.total_left      = tot_l;
        res.total_right     = tot_r;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [47:0] got, input logic [47:0] exp);
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d, %s: expected %h, got %h", results_seen, name, exp, got);
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, odo_expect_q.size());
      $display("tb_encoder_odometry_accumulator NOT OK");
      $finish;
    end
  end

  // score the output beat first, then predict from the input beat
  always @(posedge clk_i) begin
    eoa_pkg::result_t got, exp;
    row_t             pin;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (odo_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %h", got);
        end else begin
          exp = odo_expect_q.pop_front();
          check_field("increment_left", 48'(got.increment_left), 48'(exp.increment_left));
          check_field("increment_right", 48'(got.increment_right), 48'(exp.increment_right));
          check_field("distance_out", got.distance, exp.distance);
          check_field("angle_out", got.angle, exp.angle);
          check_field("wheel_left", got.wheel_left, exp.wheel_left);
          check_field("wheel_right", got.wheel_right, exp.wheel_right);
          check_field("total_left_out", 48'(got.total_left), 48'(exp.total_left));
          check_field("total_right_out", 48'(got.total_right), 48'(exp.total_right));
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pin = pin_q.pop_front();
        if (odo_advance(s_axis_tuser, s_axis_tdata[0], exp))
          odo_expect_q.push_back(pin.pin ? pin.val : exp);
        beats_in++;
      end
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic drive_beat(input logic [1:0] act, input logic b, input logic pin,
                            input eoa_pkg::result_t val);
    row_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    r = '{act, b, pin, val};
    pin_q.push_back(r);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, b};
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (odo_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      eoa_pkg::REG_LEFT_REV:  rev_l = val[0];
      eoa_pkg::REG_RIGHT_REV: rev_r = val[0];
      eoa_pkg::REG_MM_LEFT:   mm_l  = val[23:0];
      eoa_pkg::REG_MM_RIGHT:  mm_r  = val[23:0];
      default:                deg   = val[23:0];
    endcase
  endtask

  task automatic write_all(input logic lr, input logic rr, input logic [23:0] ml,
                           input logic [23:0] mr, input logic [23:0] dg);
    reg_write(eoa_pkg::REG_LEFT_REV, {31'd0, lr});
    reg_write(eoa_pkg::REG_RIGHT_REV, {31'd0, rr});
    reg_write(eoa_pkg::REG_MM_LEFT, {8'd0, ml});
    reg_write(eoa_pkg::REG_MM_RIGHT, {8'd0, mr});
    reg_write(eoa_pkg::REG_DEG, {8'd0, dg});
  endtask

  function automatic logic [23:0] pick_scale();
    case ($urandom_range(4))
      0:       return 24'd0;
      1:       return SCALE_MAX;
      2:       return eoa_pkg::MM_PER_COUNT_RESET;
      3:       return 24'($urandom_range(200000));
      default: return 24'($urandom);
    endcase
  endfunction

  // mostly edge bursts closed by a tick, with clears and loose beats mixed in
  task automatic run_mix(input int target);
    int sent, n, k, pick;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        drive_beat(eoa_pkg::ACT_CLEAR, 1'($urandom_range(1)), 1'b0, '0);
        sent++;
      end else if (pick < 14) begin
        drive_beat(2'($urandom_range(3)), 1'($urandom_range(1)), 1'b0, '0);
        sent++;
      end else begin
        n = ($urandom_range(19) == 0) ? $urandom_range(180, 140) : $urandom_range(12);
        for (k = 0; k < n; k++)
          drive_beat($urandom_range(1) ? eoa_pkg::ACT_RIGHT : eoa_pkg::ACT_LEFT,
                     1'($urandom_range(1)), 1'b0, '0);
        drive_beat(eoa_pkg::ACT_TICK, 1'($urandom_range(1)), 1'b0, '0);
        sent += n + 1;
      end
    end
  endtask

  initial begin
    int               k, ph;
    int               idle_tab[4];
    int               stall_tab[4];
    eoa_pkg::result_t zero_res;
    idle_tab  = '{0, 52, 0, 24};
    stall_tab = '{0, 0, 52, 24};
    zero_res  = '0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = eoa_pkg::ACT_LEFT;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    mismatches     = 0;
    beats_in       = 0;
    results_seen   = 0;
    per_l = '0;  per_r = '0;  tot_l = '0;  tot_r = '0;
    whl_l = '0;  whl_r = '0;  trav  = '0;  head  = '0;
    rev_l = 1'b0;
    rev_r = 1'b0;
    mm_l  = eoa_pkg::MM_PER_COUNT_RESET;
    mm_r  = eoa_pkg::MM_PER_COUNT_RESET;
    deg   = eoa_pkg::DEG_PER_MM_RESET;

    dir_rows = '{
      '{eoa_pkg::ACT_TICK,  1'b0, 1'b1, zero_res},
      '{eoa_pkg::ACT_LEFT,  1'b1, 1'b0, zero_res},
      '{eoa_pkg::ACT_TICK,  1'b1, 1'b1, pinned(18000, 0, 9000, -12635, 18000, 0, 1, 0)},
      '{eoa_pkg::ACT_RIGHT, 1'b1, 1'b0, zero_res},
      '{eoa_pkg::ACT_RIGHT, 1'b1, 1'b0, zero_res},
      '{eoa_pkg::ACT_LEFT,  1'b0, 1'b0, zero_res},
      '{eoa_pkg::ACT_TICK,  1'b0, 1'b0, zero_res},
      '{eoa_pkg::ACT_CLEAR, 1'b1, 1'b0, zero_res},
      '{eoa_pkg::ACT_TICK,  1'b0, 1'b1, zero_res},
      '{eoa_pkg::ACT_RIGHT, 1'b0, 1'b0, zero_res},
      '{eoa_pkg::ACT_LEFT,  1'b1, 1'b0, zero_res},
      '{eoa_pkg::ACT_CLEAR, 1'b0, 1'b0, zero_res},
      '{eoa_pkg::ACT_TICK,  1'b1, 1'b1, zero_res},
      '{eoa_pkg::ACT_LEFT,  1'b0, 1'b0, zero_res},
      '{eoa_pkg::ACT_LEFT,  1'b0, 1'b0, zero_res},
      '{eoa_pkg::ACT_RIGHT, 1'b1, 1'b0, zero_res},
      '{eoa_pkg::ACT_RIGHT, 1'b0, 1'b0, zero_res},
      '{eoa_pkg::ACT_TICK,  1'b1, 1'b0, zero_res},
      '{eoa_pkg::ACT_TICK,  1'b0, 1'b0, zero_res}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      drive_beat(dir_rows[i].act, dir_rows[i].b, dir_rows[i].pin, dir_rows[i].val);
    drain();

    // stall the output so the command queue fills and input backs up
    hold_req = 1'b1;
    for (k = 0; k < 24; k++)
      drive_beat(k[0] ? eoa_pkg::ACT_TICK : eoa_pkg::ACT_LEFT, 1'($urandom_range(1)), 1'b0, '0);
    drain();

    // saturate both increments from a cleared state with reversed wheels
    write_all(1'b1, 1'b1, SCALE_MAX, SCALE_MAX, SCALE_MAX);
    drive_beat(eoa_pkg::ACT_CLEAR, 1'b0, 1'b0, '0);
    for (k = 0; k < SAT_EDGES; k++) drive_beat(eoa_pkg::ACT_RIGHT, 1'b0, 1'b0, '0);
    for (k = 0; k < SAT_EDGES; k++) drive_beat(eoa_pkg::ACT_LEFT, 1'b1, 1'b0, '0);
    drive_beat(eoa_pkg::ACT_TICK, 1'b0, 1'b1,
               pinned(-64'sd2147483648, 64'sd2147483647, -1, 64'sd1099511561984,
                      -64'sd2147483648, 64'sd2147483647, -130, 130));
    drain();

    for (ph = 0; ph < 4; ph++) begin
      write_all(1'($urandom_range(1)), 1'($urandom_range(1)), pick_scale(), pick_scale(),
                pick_scale());
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      run_mix(MIX_ITEMS);
      drain();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
    write_all(1'b0, 1'b0, 24'd0, 24'd0, 24'd0);
    run_mix(40);
    drain();

    $display("covered %0d input beats and %0d odometry results over directed, increment",
             beats_in, results_seen);
    $display("saturation, back-pressure and four handshake-idling phases; %0d mismatches",
             mismatches);
    if (mismatches == 0 && odo_expect_q.size() == 0) begin
      $display("tb_encoder_odometry_accumulator OK");
    end else begin
      $display("tb_encoder_odometry_accumulator NOT OK");
    end
    $finish;
  end

endmodule

>>> encoder_odometry_accumulator.f
src/eoa_pkg.sv
src/eoa_cfg_regs.sv
src/eoa_front.sv
src/eoa_back.sv
src/encoder_odometry_accumulator.sv
tb/tb_encoder_odometry_accumulator.sv
